@@ design/ecpr_pkg.sv @@
`default_nettype none

package ecpr_pkg;

	// sizing
	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 8;
	localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W      = 4;
	localparam int MISS_W     = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

	// per-cell command from the sequencer
	typedef struct packed {
		logic lookup_en;
		logic load;
		logic touch;
	} cell_cmd_t;

	// broadcast scan control
	typedef struct packed {
		logic advance;
		logic clear;
		logic seek_dirty;
	} scan_ctl_t;

	// per-cell status back to the sequencer
	typedef struct packed {
		logic                 match;
		logic                 cand;
		logic                 tok;
		logic                 dirty;
		logic [PAGE_BITS-1:0] page;
	} cell_stat_t;

	// frame count with out-of-range values clamped to 1..MAX_FRAMES
	function automatic logic [CNT_W-1:0] eff_frames(input logic [CFG_W-1:0] cfg);
		int v;
		v = int'(cfg);
		if (v < 1) v = 1;
		if (v > MAX_FRAMES) v = MAX_FRAMES;
		return CNT_W'(v);
	endfunction

endpackage

`default_nettype wire

@@ design/ecpr_cell.sv @@
`default_nettype none

module ecpr_cell import ecpr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cell_cmd_t            cmd,
	input  wire scan_ctl_t            scan,
	input  wire logic [PAGE_BITS-1:0] page,
	input  wire logic                 wr,
	input  wire logic                 tok_in,
	output cell_stat_t                stat
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 ref_q;
	logic                 dirty_q;
	logic                 tok_q;

	// resident page, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page;
		end
	end

	// reference and dirty bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.load) begin
			ref_q   <= 1'b1;
			dirty_q <= wr;
		end else if (cmd.touch) begin
			ref_q   <= 1'b1;
			dirty_q <= dirty_q | wr;
		end else if (scan.advance && tok_q && scan.seek_dirty) begin
			// second-chance pass clears the bit as the hand goes by
			ref_q <= 1'b0;
		end
	end

	// clock hand token, handed to the neighbor on each advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (scan.clear) begin
			tok_q <= 1'b0;
		end else if (scan.advance) begin
			tok_q <= tok_in;
		end
	end

	// status
	always_comb begin
		stat.match = cmd.lookup_en && (page_q == page);
		stat.cand  = tok_q && !ref_q && (dirty_q == scan.seek_dirty);
		stat.tok   = tok_q;
		stat.dirty = dirty_q;
		stat.page  = page_q;
	end

endmodule

`default_nettype wire

@@ design/enhanced_clock_page_replacer.sv @@
// a hit or a cold fill is decided in the lookup state and registered as the result
// a replacement goes on to a scan state in which the clock hand visits the frames in turn,
// wrapping at the clamped frame count, the hand walking the cell row one frame a cycle
// one access in flight; the next is taken the cycle after its result is registered
// reset clears reference and dirty bits, fill count, miss count; frame count goes to 3
`default_nettype none

module enhanced_clock_page_replacer import ecpr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]     frames_in_use,
	// access channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PAGE_BITS-1:0] page_number,
	input  wire logic                 is_write,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [FRAME_W-1:0]        frame_index,
	output logic                      evicted_valid,
	output logic [PAGE_BITS-1:0]      evicted_page,
	output logic                      evicted_dirty,
	output logic [MISS_W-1:0]         miss_total
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]           state_q;
	logic [CFG_W-1:0]     frames_q;
	logic [CNT_W-1:0]     filled_q;
	logic [MISS_W-1:0]    miss_q;
	logic [1:0]           pass_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 wr_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   frame_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic                 ev_dirty_q;

	logic [CNT_W-1:0]     n_eff;
	logic                 out_free;
	logic                 in_take;

	cell_cmd_t            cmd [MAX_FRAMES];
	cell_stat_t           stat [MAX_FRAMES];
	scan_ctl_t            scan;
	logic [MAX_FRAMES-1:0] tok_in;
	logic [MAX_FRAMES-1:0] match_v;
	logic [MAX_FRAMES-1:0] cand_v;
	logic [MAX_FRAMES-1:0] tok_v;
	logic [MAX_FRAMES-1:0] last_v;
	logic                 wrap;
	logic                 scan_start;

	logic [FRAME_W-1:0]   hit_idx;
	logic [FRAME_W-1:0]   vic_idx;
	logic [PAGE_BITS-1:0] vic_page;
	logic                 vic_dirty;

	logic                 fin;
	logic                 fin_hit;
	logic [FRAME_W-1:0]   fin_frame;
	logic                 fin_ev;
	logic                 fin_miss;
	logic [MAX_FRAMES-1:0] load_v;
	logic [MAX_FRAMES-1:0] touch_v;
	logic                 fill;
	logic                 pass_inc;

	assign n_eff     = eff_frames(frames_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// cell row
	for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
		if (gi == 0) begin : g_head
			assign tok_in[gi] = scan_start | wrap;
		end else begin : g_body
			assign tok_in[gi] = stat[gi-1].tok & ~last_v[gi-1];
		end

		always_comb begin
			cmd[gi].lookup_en = (CNT_W'(gi) < filled_q) && (CNT_W'(gi) < n_eff);
			cmd[gi].load      = load_v[gi];
			cmd[gi].touch     = touch_v[gi];
		end

		ecpr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[gi]),
			.scan   (scan),
			.page   (page_q),
			.wr     (wr_q),
			.tok_in (tok_in[gi]),
			.stat   (stat[gi])
		);
	end

	// gather status, encode lowest match and the claimed frame
	always_comb begin
		hit_idx   = '0;
		vic_idx   = '0;
		vic_page  = '0;
		vic_dirty = 1'b0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match_v[i] = stat[i].match;
			cand_v[i]  = stat[i].cand;
			tok_v[i]   = stat[i].tok;
			last_v[i]  = (CNT_W'(i) == n_eff - CNT_W'(1));
			if (cand_v[i]) begin
				vic_page  = vic_page | stat[i].page;
				vic_dirty = vic_dirty | stat[i].dirty;
			end
		end
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match_v[i]) hit_idx = FRAME_W'(i);
			if (cand_v[i])  vic_idx = FRAME_W'(i);
		end
	end

	assign wrap = |(tok_v & last_v);

	// sequencer decisions
	always_comb begin
		fin        = 1'b0;
		fin_hit    = 1'b0;
		fin_frame  = '0;
		fin_ev     = 1'b0;
		fin_miss   = 1'b0;
		fill       = 1'b0;
		load_v     = '0;
		touch_v    = '0;
		scan_start = 1'b0;
		pass_inc   = 1'b0;
		scan.advance    = 1'b0;
		scan.clear      = 1'b0;
		scan.seek_dirty = pass_q[0];
		case (state_q)
			ST_LOOK: begin
				if (|match_v) begin
					if (out_free) begin
						fin        = 1'b1;
						fin_hit    = 1'b1;
						fin_frame  = hit_idx;
						touch_v[hit_idx] = 1'b1;
					end
				end else if (filled_q < n_eff) begin
					// cold fill of the next empty frame
					if (out_free) begin
						fin       = 1'b1;
						fin_miss  = 1'b1;
						fill      = 1'b1;
						fin_frame = FRAME_W'(filled_q);
						for (int i = 0; i < MAX_FRAMES; i++) begin
							load_v[i] = (CNT_W'(i) == filled_q);
						end
					end
				end else begin
					// put the hand on frame 0
					scan_start      = 1'b1;
					scan.advance    = 1'b1;
					scan.seek_dirty = 1'b0;
				end
			end
			ST_SCAN: begin
				if (|cand_v) begin
					if (out_free) begin
						fin        = 1'b1;
						fin_miss   = 1'b1;
						fin_ev     = 1'b1;
						fin_frame  = vic_idx;
						scan.clear = 1'b1;
						load_v[vic_idx] = 1'b1;
					end
				end else begin
					scan.advance = 1'b1;
					pass_inc     = wrap;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			frames_q <= CFG_RESET;
			filled_q <= '0;
			miss_q   <= '0;
			pass_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frames_q <= frames_in_use;
			end
			if (fill) begin
				filled_q <= filled_q + CNT_W'(1);
			end
			if (fin_miss && (miss_q != '1)) begin
				miss_q <= miss_q + MISS_W'(1);
			end
			if (scan_start) begin
				pass_q <= '0;
			end else if (pass_inc) begin
				pass_q <= pass_q + 2'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end else if (scan_start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fin) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// accepted access
	always_ff @(posedge clk) begin
		if (in_take) begin
			page_q <= page_number;
			wr_q   <= is_write;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin) begin
			hit_q      <= fin_hit;
			frame_q    <= fin_frame;
			ev_valid_q <= fin_ev;
			ev_page_q  <= fin_ev ? vic_page : '0;
			ev_dirty_q <= fin_ev ? vic_dirty : 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign evicted_dirty = ev_dirty_q;
	assign miss_total    = miss_q;

endmodule

`default_nettype wire
